>>> design/fnhf_pkg.sv
// Package for the frame number hole finder.
// Holds field widths and parameter defaults; no dependencies.
package fnhf_pkg;

  localparam int DATA_W = 64;
  localparam int LEN_W  = 6;

  localparam int WORD_BITS_DEF = 64;
  localparam int PAGE_BITS_DEF = 12;

endpackage

>>> design/fnhf_if.sv
// Channel interfaces for the frame number hole finder: request and result.
// Depends on fnhf_pkg for field widths.
interface fnhf_req_if;
  logic                        valid;
  logic                        ready;
  logic [fnhf_pkg::DATA_W-1:0] frame_mask;

  modport source (output valid, output frame_mask, input ready);
  modport sink   (input valid, input frame_mask, output ready);
endinterface

interface fnhf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [fnhf_pkg::LEN_W-1:0]  hole_length;
  logic [fnhf_pkg::LEN_W-1:0]  hole_start;
  logic [fnhf_pkg::DATA_W-1:0] low_frame_mask;
  logic [fnhf_pkg::DATA_W-1:0] low_address_mask;
  logic [fnhf_pkg::DATA_W-1:0] hole_bits_mask;
  logic [fnhf_pkg::DATA_W-1:0] high_frame_mask;
  logic [fnhf_pkg::DATA_W-1:0] high_address_mask;

  modport source (output valid, output found, output hole_length, output hole_start,
                  output low_frame_mask, output low_address_mask, output hole_bits_mask,
                  output high_frame_mask, output high_address_mask, input ready);
  modport sink   (input valid, input found, input hole_length, input hole_start,
                  input low_frame_mask, input low_address_mask, input hole_bits_mask,
                  input high_frame_mask, input high_address_mask, output ready);
endinterface

>>> design/frame_number_hole_finder_unit.sv
// Frame number hole finder: bit-serial scan for the longest bounded zero run,
// then derivation of the compression masks. Depends on fnhf_pkg and fnhf_if.
//
//   channel  direction  payload
//   req      in         frame_mask
//   rsp      out        found, hole_length, hole_start, five 64-bit masks
//
// An item is loaded, then scanned word bit by word bit through the run length
// compare, and then the masks are built.
// rst is synchronous and clears the sequencer and the result valid.
// A result waiting on rsp does not block the next request; the mask build
// stalls until the result register is free.
module frame_number_hole_finder_unit #(
  parameter int WORD_BITS = fnhf_pkg::WORD_BITS_DEF,
  parameter int PAGE_BITS = fnhf_pkg::PAGE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  fnhf_req_if.sink       req,
  fnhf_rsp_if.source     rsp
);

  localparam int DW   = fnhf_pkg::DATA_W;
  localparam int LW   = fnhf_pkg::LEN_W;
  localparam int IW   = $clog2(WORD_BITS);
  localparam int SW   = LW + 1;
  localparam int PAGE = PAGE_BITS % 64;
  localparam logic [IW-1:0] LAST = IW'(WORD_BITS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_BUILD} state_t;

  state_t                 state;
  logic [WORD_BITS-1:0]   word;
  logic [IW-1:0]          idx;
  logic                   in_run;
  logic [IW-1:0]          run_at;
  logic [IW-1:0]          best_len;
  logic [IW-1:0]          best_at;

  logic                   out_valid;
  logic                   out_found;
  logic [LW-1:0]          out_len;
  logic [LW-1:0]          out_start;
  logic [DW-1:0]          out_lf, out_la, out_hm, out_hf, out_ha;

  logic [IW-1:0]          run_len;
  logic                   better;
  logic                   found;
  logic [SW-1:0]          at_w, end_w, addr_w;
  logic [DW-1:0]          wm, lf, la, hm, hf, ha;
  logic                   free;

  assign run_len = idx - run_at;
  assign better  = in_run && word[0] && (run_len > best_len);
  assign found   = best_len != '0;
  assign free    = !out_valid || rsp.ready;

  always_comb begin
    at_w   = SW'(best_at);
    end_w  = SW'(best_at) + SW'(best_len);
    addr_w = SW'(best_at) + SW'(PAGE);
    wm = '0;
    lf = '0;
    la = '0;
    hm = '0;
    hf = '0;
    ha = '0;
    for (int i = 0; i < DW; i++) begin
      wm[i] = i < WORD_BITS;
      lf[i] = wm[i] && (SW'(i) < at_w);
      hm[i] = wm[i] && (SW'(i) >= at_w) && (SW'(i) < end_w);
      hf[i] = wm[i] && !lf[i] && !hm[i];
      la[i] = wm[i] && ((addr_w >= SW'(DW)) || (SW'(i) < addr_w));
      if (i >= PAGE) begin
        ha[i] = wm[i] && hf[i-PAGE];
      end
    end
    if (!found) begin
      lf = wm;
      la = wm;
      hm = '0;
      hf = '0;
      ha = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_BUILD && free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            word     <= req.frame_mask[WORD_BITS-1:0];
            idx      <= '0;
            in_run   <= 1'b0;
            run_at   <= '0;
            best_len <= '0;
            best_at  <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!word[0] && !in_run) begin
            in_run <= 1'b1;
            run_at <= idx;
          end else if (word[0]) begin
            in_run <= 1'b0;
          end
          if (better) begin
            best_len <= run_len;
            best_at  <= run_at;
          end
          word <= word >> 1;
          idx  <= idx + 1'b1;
          if (idx == LAST) begin
            state <= S_BUILD;
          end
        end
        S_BUILD: begin
          if (free) begin
            out_found <= found;
            out_len   <= LW'(best_len);
            out_start <= LW'(best_at);
            out_lf    <= lf;
            out_la    <= la;
            out_hm    <= hm;
            out_hf    <= hf;
            out_ha    <= ha;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready             = state == S_IDLE;
  assign rsp.valid             = out_valid;
  assign rsp.found             = out_found;
  assign rsp.hole_length       = out_len;
  assign rsp.hole_start        = out_start;
  assign rsp.low_frame_mask    = out_lf;
  assign rsp.low_address_mask  = out_la;
  assign rsp.hole_bits_mask    = out_hm;
  assign rsp.high_frame_mask   = out_hf;
  assign rsp.high_address_mask = out_ha;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while scan in progress");

  a_no_run_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.hole_length == '0 && rsp.hole_start == '0
                                && rsp.hole_bits_mask == '0)
    else $error("empty result carries a run");

  a_masks_partition: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |->
      (rsp.low_frame_mask & rsp.hole_bits_mask) == '0 &&
      (rsp.hole_bits_mask & rsp.high_frame_mask) == '0 &&
      (rsp.low_frame_mask | rsp.hole_bits_mask | rsp.high_frame_mask) == wm)
    else $error("frame masks do not partition the word");

  a_found_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.hole_length != '0)
    else $error("found result with zero length");

endmodule

>>> tb/sv/tb_frame_number_hole_finder_unit.sv
// Testbench for frame_number_hole_finder_unit: drives frame masks, predicts the
// chosen zero run and the derived compression masks, and checks every result.
// Depends on fnhf_pkg and the fnhf_req_if / fnhf_rsp_if channel interfaces.
module tb_frame_number_hole_finder_unit;

  localparam int DATA_W     = fnhf_pkg::DATA_W;
  localparam int LEN_W      = fnhf_pkg::LEN_W;
  localparam int WORD       = fnhf_pkg::WORD_BITS_DEF;
  localparam int PAGE       = fnhf_pkg::PAGE_BITS_DEF;
  localparam int N_RANDOM   = 1530;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [DATA_W-1:0] mask;
    bit                drain;
  } frame_item_t;

  typedef struct {
    logic              found;
    logic [LEN_W-1:0]  hole_length;
    logic [LEN_W-1:0]  hole_start;
    logic [DATA_W-1:0] low_frame_mask;
    logic [DATA_W-1:0] low_address_mask;
    logic [DATA_W-1:0] hole_bits_mask;
    logic [DATA_W-1:0] high_frame_mask;
    logic [DATA_W-1:0] high_address_mask;
  } hole_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fnhf_req_if req ();
  fnhf_rsp_if rsp ();

  frame_number_hole_finder_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  frame_item_t  frame_items[$];
  hole_result_t expected_holes[$];

  bit req_taken = 1'b0;
  bit rsp_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int sent_count = 0;
  int rsp_count = 0;
  int idle_cycles = 0;
  int fail_count = 0;

  always #10 clk = ~clk;

  function automatic logic [DATA_W-1:0] ones_up_to(int n);
    if (n >= DATA_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic hole_result_t predict_hole(logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] word_mask;
    logic [DATA_W-1:0] bits;
    int                best_len;
    int                best_at;
    int                run_at;
    bit                in_run;
    hole_result_t      r;
    word_mask = ones_up_to(WORD);
    bits      = raw & word_mask;
    best_len  = 0;
    best_at   = 0;
    run_at    = 0;
    in_run    = 1'b0;
    for (int b = 0; b < WORD; b++) begin
      if (!bits[b]) begin
        if (!in_run) begin
          in_run = 1'b1;
          run_at = b;
        end
      end else if (in_run) begin
        if (b - run_at > best_len) begin
          best_len = b - run_at;
          best_at  = run_at;
        end
        in_run = 1'b0;
      end
    end
    r.found       = (best_len != 0);
    r.hole_length = best_len[LEN_W-1:0];
    r.hole_start  = best_at[LEN_W-1:0];
    if (best_len == 0) begin
      r.low_frame_mask    = word_mask;
      r.low_address_mask  = word_mask;
      r.hole_bits_mask    = '0;
      r.high_frame_mask   = '0;
      r.high_address_mask = '0;
    end else begin
      r.low_frame_mask    = ones_up_to(best_at);
      r.low_address_mask  = ones_up_to(PAGE + best_at) & word_mask;
      r.hole_bits_mask    = ones_up_to(best_len) << best_at;
      r.high_frame_mask   = ~(r.low_frame_mask | r.hole_bits_mask) & word_mask;
      r.high_address_mask = (r.high_frame_mask << PAGE) & word_mask;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_frame_mask();
    logic [DATA_W-1:0] m;
    int                s;
    int                l;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        m = '0;
        for (int k = $urandom_range(1, 4); k > 0; k--) m[$urandom_range(0, 63)] = 1'b1;
      end
      2: begin
        m = '1;
        for (int k = $urandom_range(1, 5); k > 0; k--) m[$urandom_range(0, 63)] = 1'b0;
      end
      default: begin
        // carve one dominant run capped by a set bit, over a dense background
        m = m | {$urandom, $urandom};
        s = $urandom_range(0, 62);
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63 - s)
                                        : $urandom_range(1, (63 - s < 8) ? 63 - s : 8);
        m = m & ~(ones_up_to(l) << s);
        m[s + l] = 1'b1;
      end
    endcase
    return m;
  endfunction

  function automatic int draw_wait(int n);
    if ((n / 90) % 3 == 1) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic add_item(logic [DATA_W-1:0] m, bit drain);
    frame_item_t it;
    it.mask  = m;
    it.drain = drain;
    frame_items.push_back(it);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    req.valid      = 1'b0;
    req.frame_mask = '0;
    rsp.ready      = 1'b0;
    add_item(64'h0000_0000_0000_0000, 1'b0);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h8000_0000_0000_0000, 1'b0);
    add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h0000_0000_0000_0001, 1'b0);
    add_item(64'h0000_0000_0000_0002, 1'b0);
    add_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_item(64'h5555_5555_5555_5555, 1'b0);
    add_item(64'h8000_0000_0000_0001, 1'b0);
    add_item(64'hFF7F_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'hC000_0000_0000_0000, 1'b0);
    add_item(64'hF00F_F00F_FFFF_FFFF, 1'b0);
    add_item(64'h8000_0000_8000_0000, 1'b0);
    add_item(64'h0000_0001_0000_0001, 1'b0);
    add_item(64'hFFF0_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h9FFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h0008_0000_0000_0000, 1'b0);
    add_item(64'hFFF8_0000_0000_0000, 1'b0);
    add_item(64'h1234_5678_9ABC_DEF0, 1'b1);
    for (int i = 0; i < N_RANDOM; i++) add_item(random_frame_mask(), i == N_RANDOM / 2);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (frame_items.size() != 0 || req.valid || expected_holes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("frame_number_hole_finder_unit: match");
    end else begin
      $display("frame_number_hole_finder_unit: mismatch");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      gap_left  <= 0;
    end else if (!(req.valid && !req_taken)) begin
      if (gap_left != 0) begin
        req.valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (frame_items.size() != 0
                   && !(frame_items[0].drain && expected_holes.size() != 0)) begin
        req.valid      <= 1'b1;
        req.frame_mask <= frame_items[0].mask;
        frame_items.delete(0);
        gap_left       <= draw_wait(sent_count);
        sent_count     <= sent_count + 1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    int n;
    if (rst) begin
      rsp.ready  <= 1'b0;
      stall_left <= draw_wait(0);
    end else if (rsp_taken) begin
      n = draw_wait(rsp_count);
      rsp.ready  <= (n == 0);
      stall_left <= (n == 0) ? 0 : n - 1;
    end else if (stall_left != 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hole_result_t e;
    req_taken <= !rst && req.valid && req.ready;
    rsp_taken <= !rst && rsp.valid && rsp.ready;
    if (!rst) begin
      if (req.valid && req.ready) expected_holes.push_back(predict_hole(req.frame_mask));
      if (rsp.valid && rsp.ready) begin
        rsp_count <= rsp_count + 1;
        if (expected_holes.size() == 0) begin
          $error("result with no frame mask outstanding");
          fail_count++;
        end else begin
          e = expected_holes.pop_front();
          check_field("found", DATA_W'(e.found), DATA_W'(rsp.found));
          check_field("hole_length", DATA_W'(e.hole_length), DATA_W'(rsp.hole_length));
          check_field("hole_start", DATA_W'(e.hole_start), DATA_W'(rsp.hole_start));
          check_field("low_frame_mask", e.low_frame_mask, rsp.low_frame_mask);
          check_field("low_address_mask", e.low_address_mask, rsp.low_address_mask);
          check_field("hole_bits_mask", e.hole_bits_mask, rsp.hole_bits_mask);
          check_field("high_frame_mask", e.high_frame_mask, rsp.high_frame_mask);
          check_field("high_address_mask", e.high_address_mask, rsp.high_address_mask);
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("frame_number_hole_finder_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

>>> sim.f
design/fnhf_pkg.sv
design/fnhf_if.sv
design/frame_number_hole_finder_unit.sv
tb/sv/tb_frame_number_hole_finder_unit.sv
